[design/mwm_pkg.sv]
// Shared types, constants and helper functions for the mecanum wheel mixer.
`timescale 1ns / 1ps
`default_nettype none
package mwm_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int CH_W          = 12;
	localparam int DB_W          = 9;
	localparam int SPD_W         = 10;
	localparam int WHEEL_W       = 11;
	localparam int IDX_W         = 2;
	localparam int CFG_W         = 12;
	localparam int FIFO_DEPTH    = 4;

	localparam logic [IDX_W-1:0] REG_STICK_CENTER = 2'd0;
	localparam logic [IDX_W-1:0] REG_DEADZONE     = 2'd1;
	localparam logic [IDX_W-1:0] REG_STICK_FULL   = 2'd2;
	localparam logic [IDX_W-1:0] REG_DRIVE_SCALE  = 2'd3;

	localparam logic [CH_W-1:0]  RST_STICK_CENTER = 12'd1500;
	localparam logic [DB_W-1:0]  RST_DEADZONE     = 9'd20;
	localparam logic [CH_W-1:0]  RST_STICK_FULL   = 12'd2000;
	localparam logic [SPD_W-1:0] RST_DRIVE_SCALE  = 10'd255;

	localparam logic [CH_W-1:0] GATE_MODE     = 12'd1900;
	localparam logic [CH_W-1:0] ROT_HIGH_EDGE = 12'd1650;
	localparam logic [CH_W-1:0] ROT_LOW_EDGE  = 12'd1350;
	localparam logic [CH_W-1:0] ROT_HIGH      = 12'd2000;
	localparam logic [CH_W-1:0] ROT_LOW       = 12'd1000;
	localparam logic [CH_W-1:0] ROT_MID       = 12'd1500;

	typedef struct packed {
		logic [CH_W-1:0]  center;
		logic [DB_W-1:0]  deadzone;
		logic [CH_W-1:0]  full;
		logic [SPD_W-1:0] drive_scale;
	} cfg_t;

	typedef struct packed {
		logic            sign;
		logic            zero;
		logic            sat;
		logic [CH_W-1:0] mag;
	} axis_t;

	typedef struct packed {
		logic            stop;
		axis_t           thr;
		axis_t           stf;
		axis_t           rot;
		logic [CH_W-1:0] span;
	} item_t;

	// floor(sqrt(2^(2*fb-1))), i.e. 1/sqrt2 in fb fraction bits
	function automatic longint unsigned half_root(input int fb);
		longint unsigned x;
		longint unsigned res;
		longint unsigned b;
		x   = 64'd1 << (2 * fb - 1);
		res = 64'd0;
		b   = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (x >= res + b) begin
				x   = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

endpackage
`default_nettype wire

[design/mwm_fifo.sv]
// Small register queue between the front classifier and the arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none
module mwm_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop,
	output logic [W-1:0] pop_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign push_ready = cnt_q != FULL;
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
			if (do_pop) rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
		end
	end
endmodule
`default_nettype wire

[design/mwm_div.sv]
// Pipelined restoring divider, one quotient bit per stage, lanes share a divisor.
`timescale 1ns / 1ps
`default_nettype none
module mwm_div #(
	parameter int LANES = 1,
	parameter int NW    = 8,
	parameter int DW    = 8,
	parameter int QW    = 8,
	parameter int SBW   = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           ce,
	input  logic           in_valid,
	input  logic [NW-1:0]  num [LANES],
	input  logic [DW-1:0]  den,
	input  logic [SBW-1:0] side_in,
	output logic           out_valid,
	output logic [QW-1:0]  quo [LANES],
	output logic [SBW-1:0] side_out
);
	localparam int TW = (NW > DW + QW) ? NW : DW + QW;

	logic [TW-1:0]  rem_s  [QW][LANES];
	logic [QW-1:0]  quo_s  [QW+1][LANES];
	logic [DW-1:0]  den_s  [QW];
	logic [SBW-1:0] side_s [QW+1];
	logic           valid_s [QW+1];

	assign den_s[0]   = den;
	assign side_s[0]  = side_in;
	assign valid_s[0] = in_valid;

	for (genvar l = 0; l < LANES; l++) begin : g_in
		assign rem_s[0][l] = TW'(num[l]);
		assign quo_s[0][l] = '0;
		assign quo[l]      = quo_s[QW][l];
	end

	for (genvar s = 0; s < QW; s++) begin : g_step
		localparam int B = QW - 1 - s;
		logic [TW-1:0] dsh;
		assign dsh = TW'(den_s[s]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[s+1] <= 1'b0;
			else if (ce) valid_s[s+1] <= valid_s[s];
		end

		always_ff @(posedge clk) begin
			if (ce) side_s[s+1] <= side_s[s];
		end

		if (s < QW - 1) begin : g_den
			always_ff @(posedge clk) begin
				if (ce) den_s[s+1] <= den_s[s];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic ge;
			assign ge = rem_s[s][l] >= dsh;
			always_ff @(posedge clk) begin
				if (ce) quo_s[s+1][l] <= quo_s[s][l] | (QW'(ge) << B);
			end
			if (s < QW - 1) begin : g_rem
				always_ff @(posedge clk) begin
					if (ce) rem_s[s+1][l] <= ge ? rem_s[s][l] - dsh : rem_s[s][l];
				end
			end
		end
	end

	assign out_valid = valid_s[QW];
	assign side_out  = side_s[QW];
endmodule
`default_nettype wire

[design/mwm_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module mwm_sqrt #(
	parameter int RW  = 8,
	parameter int SBW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ce,
	input  logic            in_valid,
	input  logic [2*RW-1:0] x,
	input  logic [SBW-1:0]  side_in,
	output logic            out_valid,
	output logic [RW-1:0]   root,
	output logic [SBW-1:0]  side_out
);
	localparam int XW = 2 * RW;

	logic [XW-1:0]  x_s    [RW];
	logic [XW-1:0]  res_s  [RW+1];
	logic [SBW-1:0] side_s [RW+1];
	logic           valid_s [RW+1];

	assign x_s[0]     = x;
	assign res_s[0]   = '0;
	assign side_s[0]  = side_in;
	assign valid_s[0] = in_valid;

	for (genvar s = 0; s < RW; s++) begin : g_step
		localparam logic [XW-1:0] BITV = XW'(1) << (2 * (RW - 1 - s));
		logic [XW-1:0] t;
		logic          ge;
		assign t  = res_s[s] + BITV;
		assign ge = x_s[s] >= t;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[s+1] <= 1'b0;
			else if (ce) valid_s[s+1] <= valid_s[s];
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				side_s[s+1] <= side_s[s];
				res_s[s+1]  <= ge ? (res_s[s] >> 1) + BITV : res_s[s] >> 1;
			end
		end

		if (s < RW - 1) begin : g_x
			always_ff @(posedge clk) begin
				if (ce) x_s[s+1] <= ge ? x_s[s] - t : x_s[s];
			end
		end
	end

	assign out_valid = valid_s[RW];
	assign root      = res_s[RW][RW-1:0];
	assign side_out  = side_s[RW];
endmodule
`default_nettype wire

[design/mwm_front.sv]
// Front end: takes input beats, applies the stop gate and pre-classifies each axis.
`timescale 1ns / 1ps
`default_nettype none
module mwm_front (
	input  logic           clk,
	input  logic           arst_n,
	input  mwm_pkg::cfg_t  cfg,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  logic [47:0]    s_axis_tdata,  // throttle_raw, strafe_raw, rotate_raw, mode_raw
	input  logic           s_axis_tuser,  // link_ok
	output logic           item_valid,
	input  logic           item_ready,
	output mwm_pkg::item_t item
);
	import mwm_pkg::*;

	logic [CH_W-1:0] thr, stf, rot, mode, rq;
	logic signed [CH_W+1:0] span_w;
	logic            span_pos;
	item_t           nxt;
	item_t           item_q;
	logic            valid_q;

	function automatic axis_t classify(input logic [CH_W-1:0] raw, input logic [CH_W-1:0] c,
			input logic [DB_W-1:0] db, input logic pos, input logic [CH_W-1:0] span);
		logic signed [CH_W:0] v;
		logic [CH_W-1:0]      amag;
		logic [CH_W-1:0]      vs;
		axis_t                a;
		v      = $signed({1'b0, raw}) - $signed({1'b0, c});
		amag   = v[CH_W] ? CH_W'(-v) : v[CH_W-1:0];
		vs     = amag - CH_W'(db);
		a.sign = v[CH_W];
		a.zero = (amag < CH_W'(db)) || (vs == '0);
		a.sat  = !pos || (vs >= span);
		a.mag  = vs;
		return a;
	endfunction

	assign thr  = s_axis_tdata[11:0];
	assign stf  = s_axis_tdata[23:12];
	assign rot  = s_axis_tdata[35:24];
	assign mode = s_axis_tdata[47:36];

	always_comb begin
		if (rot > ROT_HIGH_EDGE) rq = ROT_HIGH;
		else if (rot < ROT_LOW_EDGE) rq = ROT_LOW;
		else rq = ROT_MID;
	end

	assign span_w   = $signed({2'b0, cfg.full}) - $signed({2'b0, cfg.center})
		- $signed({5'b0, cfg.deadzone});
	assign span_pos = !span_w[CH_W+1] && (span_w != '0);

	always_comb begin
		nxt.stop = !s_axis_tuser || (mode > GATE_MODE);
		nxt.thr  = classify(thr, cfg.center, cfg.deadzone, span_pos, span_w[CH_W-1:0]);
		nxt.stf  = classify(stf, cfg.center, cfg.deadzone, span_pos, span_w[CH_W-1:0]);
		nxt.rot  = classify(rq, cfg.center, cfg.deadzone, span_pos, span_w[CH_W-1:0]);
		nxt.span = span_w[CH_W-1:0];
	end

	assign s_axis_tready = !valid_q || item_ready;
	assign item_valid    = valid_q;
	assign item          = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (s_axis_tready) valid_q <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) item_q <= nxt;
	end
endmodule
`default_nettype wire

[design/mwm_back.sv]
// Back end: fixed-point mixing pipeline from classified frame to wheel drives.
`timescale 1ns / 1ps
`default_nettype none
module mwm_back #(
	parameter int FRAC_BITS = mwm_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [mwm_pkg::SPD_W-1:0] drive_scale,
	input  logic                      in_valid,
	input  mwm_pkg::item_t            in_item,
	output logic                      in_pop,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [47:0]               m_axis_tdata,  // front_left, front_right, rear_left, rear_right
	output logic                      m_axis_tuser   // stopped
);
	import mwm_pkg::*;

	localparam int F    = FRAC_BITS;
	localparam int AW   = F + 2;
	localparam int MAGW = F + 1;
	localparam int CW   = F + 3;
	localparam int SQW  = 2 * F + 2;
	localparam int PKW  = 2 * F + 2;
	localparam int WW   = F + 4;
	localparam int WMW  = F + 3;
	localparam int N1   = CH_W + F;
	localparam int N2   = 2 * F + 2;
	localparam int N3   = 2 * F + 3;
	localparam int SPW  = F + 1 + SPD_W;

	localparam logic [AW-1:0]  ONE_A  = AW'(1) << F;
	localparam logic [SQW-1:0] ONE_SQ = SQW'(1) << (2 * F);
	localparam logic [WMW-1:0] ONE_W  = WMW'(1) << F;
	localparam logic [F-1:0]   KC     = F'(half_root(F));

	typedef struct packed {
		logic       stop;
		logic [2:0] sign;
		logic [2:0] zero;
		logic [2:0] sat;
	} ax_side_t;

	typedef struct packed {
		logic                 stop;
		logic                 need;
		logic signed [AW-1:0] r;
		logic signed [CW-1:0] cp;
		logic signed [CW-1:0] cm;
	} mix_side_t;

	typedef struct packed {
		logic                  stop;
		logic                  need;
		logic [3:0]            sign;
		logic [3:0][WMW-1:0]   mag;
	} nrm_side_t;

	function automatic logic signed [AW-1:0] axis_val(input logic sign, input logic zero,
			input logic sat, input logic [F-1:0] q);
		logic [AW-1:0] mag;
		mag = zero ? '0 : (sat ? ONE_A : AW'(q));
		return sign ? -mag : mag;
	endfunction

	function automatic logic [CW-2:0] abs_c(input logic signed [CW-1:0] x);
		logic [CW-1:0] t;
		t = x[CW-1] ? -x : x;
		return t[CW-2:0];
	endfunction

	logic ce;
	assign ce     = !m_axis_tvalid || m_axis_tready;
	assign in_pop = ce && in_valid;

	// stage 1: take from queue
	item_t item_s1;
	logic  valid_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (ce) valid_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (ce) item_s1 <= in_item;
	end

	// axis scaling divider
	logic [N1-1:0] d1_num [3];
	logic [F-1:0]  d1_q [3];
	ax_side_t      d1_si, d1_so;
	logic          d1_valid;

	assign d1_num[0] = {item_s1.thr.mag, {F{1'b0}}};
	assign d1_num[1] = {item_s1.stf.mag, {F{1'b0}}};
	assign d1_num[2] = {item_s1.rot.mag, {F{1'b0}}};
	assign d1_si.stop = item_s1.stop;
	assign d1_si.sign = {item_s1.rot.sign, item_s1.stf.sign, item_s1.thr.sign};
	assign d1_si.zero = {item_s1.rot.zero, item_s1.stf.zero, item_s1.thr.zero};
	assign d1_si.sat  = {item_s1.rot.sat, item_s1.stf.sat, item_s1.thr.sat};

	mwm_div #(.LANES(3), .NW(N1), .DW(CH_W), .QW(F), .SBW($bits(ax_side_t))) u_div_axis (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_valid(valid_s1),
		.num(d1_num), .den(item_s1.span), .side_in(d1_si),
		.out_valid(d1_valid), .quo(d1_q), .side_out(d1_so)
	);

	// stage 2: signed axis values
	logic signed [AW-1:0] vy_s2, vx_s2, r_s2;
	logic                 stop_s2, valid_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (ce) valid_s2 <= d1_valid;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			vy_s2   <= axis_val(d1_so.sign[0], d1_so.zero[0], d1_so.sat[0], d1_q[0]);
			vx_s2   <= axis_val(d1_so.sign[1], d1_so.zero[1], d1_so.sat[1], d1_q[1]);
			r_s2    <= axis_val(d1_so.sign[2], d1_so.zero[2], d1_so.sat[2], d1_q[2]);
			stop_s2 <= d1_so.stop;
		end
	end

	// stage 3: squared length and translation sums
	logic [MAGW-1:0]      ax, ay;
	logic [SQW-1:0]       sq_s3;
	logic signed [CW-1:0] cp_s3, cm_s3;
	logic signed [AW-1:0] r_s3;
	logic                 stop_s3, valid_s3;

	assign ax = MAGW'(vx_s2[AW-1] ? -vx_s2 : vx_s2);
	assign ay = MAGW'(vy_s2[AW-1] ? -vy_s2 : vy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else if (ce) valid_s3 <= valid_s2;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			sq_s3   <= SQW'(ax) * SQW'(ax) + SQW'(ay) * SQW'(ay);
			cp_s3   <= CW'(vy_s2) + CW'(vx_s2);
			cm_s3   <= CW'(vy_s2) - CW'(vx_s2);
			r_s3    <= r_s2;
			stop_s3 <= stop_s2;
		end
	end

	// vector length
	mix_side_t       m_si, m_so;
	logic [MAGW-1:0] rt;
	logic            sq_valid;

	assign m_si.stop = stop_s3;
	assign m_si.need = sq_s3 > ONE_SQ;
	assign m_si.r    = r_s3;
	assign m_si.cp   = cp_s3;
	assign m_si.cm   = cm_s3;

	mwm_sqrt #(.RW(MAGW), .SBW($bits(mix_side_t))) u_sqrt (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_valid(valid_s3),
		.x(sq_s3), .side_in(m_si),
		.out_valid(sq_valid), .root(rt), .side_out(m_so)
	);

	// unit-length shrink
	logic [N2-1:0]   d2_num [2];
	logic [MAGW-1:0] d2_q [2];
	mix_side_t       d2_so;
	logic            d2_valid;

	assign d2_num[0] = {abs_c(m_so.cp), {F{1'b0}}};
	assign d2_num[1] = {abs_c(m_so.cm), {F{1'b0}}};

	mwm_div #(.LANES(2), .NW(N2), .DW(MAGW), .QW(MAGW), .SBW($bits(mix_side_t))) u_div_len (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_valid(sq_valid),
		.num(d2_num), .den(rt), .side_in(m_so),
		.out_valid(d2_valid), .quo(d2_q), .side_out(d2_so)
	);

	// stage 4: pick shrunk or original
	logic signed [CW-1:0] cpn_s4, cmn_s4;
	logic signed [AW-1:0] r_s4;
	logic                 stop_s4, valid_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s4 <= 1'b0;
		else if (ce) valid_s4 <= d2_valid;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			cpn_s4  <= !d2_so.need ? d2_so.cp :
				(d2_so.cp[CW-1] ? -CW'(d2_q[0]) : CW'(d2_q[0]));
			cmn_s4  <= !d2_so.need ? d2_so.cm :
				(d2_so.cm[CW-1] ? -CW'(d2_q[1]) : CW'(d2_q[1]));
			r_s4    <= d2_so.r;
			stop_s4 <= d2_so.stop;
		end
	end

	// stage 5: times 1/sqrt2
	logic [PKW-1:0]       pkp, pkm;
	logic signed [CW-1:0] cpk_s5, cmk_s5;
	logic signed [AW-1:0] r_s5;
	logic                 stop_s5, valid_s5;

	assign pkp = PKW'(abs_c(cpn_s4)) * PKW'(KC);
	assign pkm = PKW'(abs_c(cmn_s4)) * PKW'(KC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s5 <= 1'b0;
		else if (ce) valid_s5 <= valid_s4;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			cpk_s5  <= cpn_s4[CW-1] ? -CW'(pkp[PKW-1:F]) : CW'(pkp[PKW-1:F]);
			cmk_s5  <= cmn_s4[CW-1] ? -CW'(pkm[PKW-1:F]) : CW'(pkm[PKW-1:F]);
			r_s5    <= r_s4;
			stop_s5 <= stop_s4;
		end
	end

	// stage 6: add rotation, find largest magnitude
	logic signed [WW-1:0] w [4];
	logic [3:0][WMW-1:0]  wa;
	logic [3:0]           ws;
	logic [WMW-1:0]       m01, m23, mx;
	logic [3:0][WMW-1:0]  wmag_s6;
	logic [3:0]           wsign_s6;
	logic [WMW-1:0]       m_s6;
	logic                 stop_s6, valid_s6;

	always_comb begin
		w[0] = WW'(cpk_s5) + WW'(r_s5);
		w[1] = WW'(cmk_s5) - WW'(r_s5);
		w[2] = WW'(cmk_s5) + WW'(r_s5);
		w[3] = WW'(cpk_s5) - WW'(r_s5);
		for (int i = 0; i < 4; i++) begin
			ws[i] = w[i][WW-1];
			wa[i] = WMW'(w[i][WW-1] ? -w[i] : w[i]);
		end
		m01 = (wa[0] > wa[1]) ? wa[0] : wa[1];
		m23 = (wa[2] > wa[3]) ? wa[2] : wa[3];
		mx  = (m01 > m23) ? m01 : m23;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s6 <= 1'b0;
		else if (ce) valid_s6 <= valid_s5;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			wmag_s6  <= wa;
			wsign_s6 <= ws;
			m_s6     <= mx;
			stop_s6  <= stop_s5;
		end
	end

	// normalization by the largest magnitude
	logic [N3-1:0]   d3_num [4];
	logic [MAGW-1:0] d3_q [4];
	nrm_side_t       d3_si, d3_so;
	logic            d3_valid;

	for (genvar l = 0; l < 4; l++) begin : g_n3
		assign d3_num[l] = {wmag_s6[l], {F{1'b0}}};
	end
	assign d3_si.stop = stop_s6;
	assign d3_si.need = m_s6 > ONE_W;
	assign d3_si.sign = wsign_s6;
	assign d3_si.mag  = wmag_s6;

	mwm_div #(.LANES(4), .NW(N3), .DW(WMW), .QW(MAGW), .SBW($bits(nrm_side_t))) u_div_norm (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_valid(valid_s6),
		.num(d3_num), .den(m_s6), .side_in(d3_si),
		.out_valid(d3_valid), .quo(d3_q), .side_out(d3_so)
	);

	// stage 7: final magnitudes
	logic [3:0][MAGW-1:0] nmag_s7;
	logic [3:0]           nsign_s7;
	logic                 stop_s7, valid_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s7 <= 1'b0;
		else if (ce) valid_s7 <= d3_valid;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 4; i++)
				nmag_s7[i] <= d3_so.need ? d3_q[i] : d3_so.mag[i][MAGW-1:0];
			nsign_s7 <= d3_so.sign;
			stop_s7  <= d3_so.stop;
		end
	end

	// output register: scale to wheel drive range
	logic [3:0][SPW-1:0]     prod;
	logic [3:0][WHEEL_W-1:0] wheel;
	logic [3:0][WHEEL_W-1:0] wheel_q;
	logic                    stop_q, out_valid_q;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			prod[i]  = SPW'(nmag_s7[i]) * SPW'(drive_scale);
			wheel[i] = nsign_s7[i] ? -prod[i][SPW-1:F] : prod[i][SPW-1:F];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (ce) out_valid_q <= valid_s7;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			wheel_q <= stop_s7 ? '0 : wheel;
			stop_q  <= stop_s7;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, wheel_q[3], wheel_q[2], wheel_q[1], wheel_q[0]};
	assign m_axis_tuser  = stop_q;
endmodule
`default_nettype wire

[design/mecanum_wheel_mixer.sv]
// Top level of the mecanum wheel mixer: config registers, front end, queue, back end.
`timescale 1ns / 1ps
`default_nettype none
// Turns one radio-control frame per beat into four signed wheel drives plus a stopped
// flag. Frames are independent, so the block accepts one frame every cycle while the
// queue has room; a frame passes through the front register, then the queue, then the
// back end with its pipelined dividers for axis scaling, length shrink and
// normalization and its pipelined square root. The front end registers and classifies
// each frame, a four-entry queue lets it keep taking beats while the arithmetic back
// end is held by a stalled output. Configuration writes take effect at once and belong
// in idle time.
module mecanum_wheel_mixer #(
	parameter int FRAC_BITS = mwm_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [mwm_pkg::IDX_W-1:0] cfg_addr,
	input  logic [mwm_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [47:0]               s_axis_tdata,  // throttle_raw, strafe_raw, rotate_raw, mode_raw
	input  logic                      s_axis_tuser,  // link_ok
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [47:0]               m_axis_tdata,  // front_left, front_right, rear_left, rear_right
	output logic                      m_axis_tuser   // stopped
);
	import mwm_pkg::*;

	cfg_t  cfg_q;
	item_t fr_item, q_item;
	logic  fr_valid, fr_ready, q_valid, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center      <= RST_STICK_CENTER;
			cfg_q.deadzone    <= RST_DEADZONE;
			cfg_q.full        <= RST_STICK_FULL;
			cfg_q.drive_scale <= RST_DRIVE_SCALE;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_STICK_CENTER: cfg_q.center      <= cfg_wdata[CH_W-1:0];
				REG_DEADZONE:     cfg_q.deadzone    <= cfg_wdata[DB_W-1:0];
				REG_STICK_FULL:   cfg_q.full        <= cfg_wdata[CH_W-1:0];
				REG_DRIVE_SCALE:  cfg_q.drive_scale <= cfg_wdata[SPD_W-1:0];
				default:          cfg_q             <= cfg_q;
			endcase
		end
	end

	mwm_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.item_valid(fr_valid), .item_ready(fr_ready), .item(fr_item)
	);

	mwm_fifo #(.W($bits(item_t)), .DEPTH(FIFO_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push_valid(fr_valid), .push_ready(fr_ready), .push_data(fr_item),
		.pop_valid(q_valid), .pop(q_pop), .pop_data(q_item)
	);

	mwm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .drive_scale(cfg_q.drive_scale),
		.in_valid(q_valid), .in_item(q_item), .in_pop(q_pop),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[43:0] == '0)
		else $error("stopped beat carries nonzero wheel drive");

	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[10:0] != 11'h400 && m_axis_tdata[21:11] != 11'h400
			&& m_axis_tdata[32:22] != 11'h400 && m_axis_tdata[43:33] != 11'h400)
		else $error("wheel drive out of range");

	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fr_valid && !fr_ready |=> fr_valid)
		else $error("front end dropped a held item");
endmodule
`default_nettype wire
